### rtl/core/tite_pkg.sv
// ----------------------------------------------------------------------------
// tite_pkg
// Shared types and constants of the transmitter id table engine.
// ----------------------------------------------------------------------------
package tite_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_W    = 5;
    localparam int REC_W     = 64;

    localparam logic [2:0] OP_FIND   = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_IDWR   = 3'd2;
    localparam logic [2:0] OP_HOPUPD = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [3:0]  EMPTY_NIBBLE = 4'hf;
    localparam logic [15:0] CLEAR_MASK   = 16'hffff;

    typedef struct packed {
        logic [2:0]  func;
        logic [23:0] serial;
        logic [7:0]  func_code;
        logic [15:0] hop_value;
        logic        learn_on;
        logic        hop_ok;
        logic        packet_is_keeloq;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       hop_count;
        logic [15:0]       hop_backup;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } state_t;

endpackage

### rtl/core/tite_req_if.sv
// ----------------------------------------------------------------------------
// tite_req_if
// Valid/ready channel carrying one table operation per transaction.
// ----------------------------------------------------------------------------
interface tite_req_if;
    logic           valid;
    logic           ready;
    tite_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/tite_rsp_if.sv
// ----------------------------------------------------------------------------
// tite_rsp_if
// Valid/ready channel carrying one operation result per transaction.
// ----------------------------------------------------------------------------
interface tite_rsp_if;
    logic           valid;
    logic           ready;
    tite_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/transmitter_id_table_engine.sv
// ----------------------------------------------------------------------------
// transmitter_id_table_engine
// Learned transmitter table: find, insert, id write, hop update, clear all.
// ----------------------------------------------------------------------------
// Find, insert and clear step through one record per cycle until a hit or the
// last record; a result still waiting holds the operation on its last step.
// Id write, hop update, find on a foreign packet and unused codes give their
// result from a single execute step. The next transaction is accepted once the
// sequencer is back in idle.
// Reset: every record all ones (empty), selected slot zero, no result pending.
// ----------------------------------------------------------------------------
module transmitter_id_table_engine (
    input  logic      clk,
    input  logic      rst_n,
    tite_req_if.sink  req,
    tite_rsp_if.source rsp
);

    localparam logic [tite_pkg::IDX_W-1:0]  LAST_IDX  =
        tite_pkg::IDX_W'(tite_pkg::NUM_SLOTS - 1);
    localparam logic [tite_pkg::SLOT_W-1:0] SLOT_NONE =
        tite_pkg::SLOT_W'(tite_pkg::NUM_SLOTS);

    tite_pkg::state_t state_reg, state_next;
    logic [tite_pkg::IDX_W-1:0]  cnt_reg, cnt_next;
    logic [tite_pkg::SLOT_W-1:0] sel_reg, sel_next;
    logic                        rsp_vld_reg, rsp_vld_next;
    tite_pkg::rsp_t              rsp_data_reg, rsp_data_next;
    tite_pkg::req_t              item_reg;

    logic [tite_pkg::REC_W-1:0] store_reg [tite_pkg::NUM_SLOTS];

    logic [tite_pkg::IDX_W-1:0] rd_idx;
    logic [tite_pkg::REC_W-1:0] rec;
    logic                       rec_empty;
    logic [23:0]                rec_serial;
    logic                       wr_en;
    logic [tite_pkg::IDX_W-1:0] wr_idx;
    logic [tite_pkg::REC_W-1:0] wr_data;
    logic                       can_load;
    logic                       hit;
    logic                       fin;
    logic                       sel_valid;

    assign req.ready  = (state_reg == tite_pkg::ST_IDLE);
    assign rsp.valid  = rsp_vld_reg;
    assign rsp.data   = rsp_data_reg;

    assign rd_idx     = (state_reg == tite_pkg::ST_EXEC) ?
                        sel_reg[tite_pkg::IDX_W-1:0] : cnt_reg;
    assign rec        = store_reg[rd_idx];
    assign rec_empty  = (rec[15:12] == tite_pkg::EMPTY_NIBBLE);
    assign rec_serial = {rec[31:16], rec[7:0]};
    assign can_load   = !rsp_vld_reg || rsp.ready;
    assign sel_valid  = (sel_reg < SLOT_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tite_pkg::ST_IDLE;
            cnt_reg     <= '0;
            sel_reg     <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            sel_reg     <= sel_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
        if (req.valid && req.ready)
        begin
            item_reg <= req.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tite_pkg::NUM_SLOTS; i++)
            begin
                store_reg[i] <= '1;
            end
        end
        else if (wr_en)
        begin
            store_reg[wr_idx] <= wr_data;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        sel_next      = sel_reg;
        rsp_vld_next  = rsp_vld_reg && !rsp.ready;
        rsp_data_next = rsp_data_reg;
        wr_en         = 1'b0;
        wr_idx        = rd_idx;
        wr_data       = rec;
        hit           = 1'b0;
        fin           = 1'b0;

        case (state_reg)
            tite_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    cnt_next = '0;
                    if ((req.data.func == tite_pkg::OP_FIND && req.data.packet_is_keeloq)
                        || req.data.func == tite_pkg::OP_INSERT
                        || req.data.func == tite_pkg::OP_CLEAR)
                    begin
                        state_next = tite_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = tite_pkg::ST_EXEC;
                    end
                end
            end

            tite_pkg::ST_SCAN:
            begin
                case (item_reg.func)
                    tite_pkg::OP_FIND:   hit = !rec_empty && (rec_serial == item_reg.serial);
                    tite_pkg::OP_INSERT: hit = rec_empty;
                    default:             hit = 1'b0;
                endcase
                fin = hit || (cnt_reg == LAST_IDX);

                // clear all: set code and serial low byte, keep the rest
                if (item_reg.func == tite_pkg::OP_CLEAR && (!fin || can_load))
                begin
                    wr_en   = 1'b1;
                    wr_data = {rec[63:16], tite_pkg::CLEAR_MASK};
                end

                if (!fin)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (can_load)
                begin
                    sel_next                 = hit ? tite_pkg::SLOT_W'(cnt_reg) : SLOT_NONE;
                    rsp_vld_next             = 1'b1;
                    rsp_data_next.ok         = hit || (item_reg.func == tite_pkg::OP_CLEAR);
                    rsp_data_next.slot       = sel_next;
                    rsp_data_next.hop_count  = '0;
                    rsp_data_next.hop_backup = '0;
                    if (hit && item_reg.func == tite_pkg::OP_FIND)
                    begin
                        rsp_data_next.hop_count  = rec[47:32];
                        rsp_data_next.hop_backup = rec[63:48];
                    end
                    state_next = tite_pkg::ST_IDLE;
                end
            end

            tite_pkg::ST_EXEC:
            begin
                if (can_load)
                begin
                    rsp_vld_next             = 1'b1;
                    rsp_data_next.ok         = 1'b0;
                    rsp_data_next.slot       = sel_reg;
                    rsp_data_next.hop_count  = '0;
                    rsp_data_next.hop_backup = '0;
                    case (item_reg.func)
                        tite_pkg::OP_IDWR:
                        begin
                            if (item_reg.learn_on && sel_valid)
                            begin
                                wr_en   = 1'b1;
                                wr_data = {rec[63:32], item_reg.serial[23:8],
                                           item_reg.func_code, item_reg.serial[7:0]};
                                rsp_data_next.ok = 1'b1;
                            end
                        end
                        tite_pkg::OP_HOPUPD:
                        begin
                            if (item_reg.hop_ok && sel_valid)
                            begin
                                wr_en   = 1'b1;
                                wr_data = {item_reg.hop_value, item_reg.hop_value,
                                           rec[31:0]};
                                rsp_data_next.ok = 1'b1;
                            end
                        end
                        default:
                        begin
                            rsp_data_next.ok = 1'b0;
                        end
                    endcase
                    state_next = tite_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tite_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/tite_checker.sv
// ----------------------------------------------------------------------------
// tite_checker
// Port-level checks of the transmitter id table engine, bound to the top.
// ----------------------------------------------------------------------------
module tite_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_ok,
    input logic [tite_pkg::SLOT_W-1:0] rsp_slot,
    input logic [15:0]                 rsp_hop_count,
    input logic [15:0]                 rsp_hop_backup
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result transaction dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while an operation is in progress");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_slot <= tite_pkg::SLOT_W'(tite_pkg::NUM_SLOTS))
        else $error("selected slot out of range");

    a_counters_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_hop_count == 16'd0 && rsp_hop_backup == 16'd0)
        else $error("counters returned by a failed operation");

endmodule

bind transmitter_id_table_engine tite_checker u_tite_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_ok         (rsp.data.ok),
    .rsp_slot       (rsp.data.slot),
    .rsp_hop_count  (rsp.data.hop_count),
    .rsp_hop_backup (rsp.data.hop_backup)
);
